// ===== hdl/ppp_pkg.sv =====
// shared types and constants for the priority particle pool
`default_nettype none
package ppp_pkg;

    localparam int POOL_SIZE = 32;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    localparam logic [15:0] GRAVITY_STEP_RST = 16'h0080;
    localparam logic [15:0] MAX_FALL_RST     = 16'h0400;
    localparam logic [7:0]  DEF_PERIOD       = 8'd4;
    localparam logic [7:0]  DEF_FRAMES       = 8'd1;

    // register indexes
    localparam logic [1:0] REG_GRAV_MASK = 2'd0;
    localparam logic [1:0] REG_GRAV_STEP = 2'd1;
    localparam logic [1:0] REG_MAX_FALL  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_FREE   = 3'd0;
    localparam logic [2:0] ST_EVICT  = 3'd1;
    localparam logic [2:0] ST_REJECT = 3'd2;
    localparam logic [2:0] ST_RECORD = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic FUNC_SPAWN = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // one pool entry as stored in memory
    typedef struct packed {
        logic [2:0]  ptype;
        logic [2:0]  pprio;
        logic [15:0] px;
        logic [15:0] py;
        logic [31:0] pvx;
        logic [31:0] pvy;
        logic [7:0]  plife;
        logic [15:0] ptile;
        logic [7:0]  ppal;
        logic [7:0]  anim_count;
        logic [7:0]  anim_len;
        logic [7:0]  cur_frame;
        logic [7:0]  num_frames;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one result record
    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic [15:0] tile;
        logic [7:0]  out_palette;
        logic [2:0]  out_prio;
        logic [5:0]  active_count;
    } result_t;

    // configuration registers handed to the update unit
    typedef struct packed {
        logic [7:0]  grav_mask;
        logic [15:0] grav_step;
        logic [15:0] max_fall;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/ppp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module ppp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/ppp_update.sv =====
// per-tick entry update: age, move, gravity and animation
`default_nettype none
module ppp_update
    import ppp_pkg::*;
(
    input  wire cfg_t   cfg,
    input  wire entry_t cur,
    output entry_t      upd
);
    logic signed [32:0] vy_sum;
    logic [15:0]        dx;
    logic [15:0]        dy;
    logic [7:0]         cnt_inc;
    logic [7:0]         frm_inc;

    always_comb begin
        upd = cur;
        upd.plife = cur.plife - 8'd1;
        // arithmetic shift by 8, low 16 bits used
        dx = cur.pvx[23:8];
        dy = cur.pvy[23:8];
        upd.px = cur.px + dx;
        upd.py = cur.py + dy;
        // gravity with clamp against max fall speed
        vy_sum = {cur.pvy[31], cur.pvy} + {17'd0, cfg.grav_step};
        if (cfg.grav_mask[cur.ptype]) begin
            if (vy_sum > $signed({17'd0, cfg.max_fall})) begin
                upd.pvy = {16'd0, cfg.max_fall};
            end else begin
                upd.pvy = vy_sum[31:0];
            end
        end
        // looping animation
        cnt_inc = cur.anim_count + 8'd1;
        frm_inc = cur.cur_frame + 8'd1;
        if (cur.num_frames > 8'd1) begin
            if (cnt_inc >= cur.anim_len) begin
                upd.anim_count = 8'd0;
                upd.cur_frame  = (frm_inc >= cur.num_frames) ? 8'd0 : frm_inc;
            end else begin
                upd.anim_count = cnt_inc;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ppp_seq.sv =====
// sequencer: scans the pool one entry a cycle for spawn and tick; report stalls while a result waits
`default_nettype none
module ppp_seq
    import ppp_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire cfg_t           cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           in_func,
    input  wire entry_t         in_entry,
    output logic                res_valid,
    input  wire logic           res_ready,
    output result_t             res_data,
    output logic                res_last
);
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_TICK   = 6'b000100,
        S_REPORT = 6'b001000,
        S_OUT    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [POOL_SIZE-1:0] alive_reg, alive_next;
    logic [IDX_W:0]       idx_reg, idx_next;     // issued read address
    logic [IDX_W:0]       pidx_reg, pidx_next;   // address of data on rdata
    logic                 pv_reg, pv_next;       // rdata is for pidx
    logic                 func_reg, func_next;
    entry_t               new_reg, new_next;
    logic                 cand_ok_reg, cand_ok_next;
    logic [IDX_W-1:0]     cand_reg, cand_next;
    logic [2:0]           cprio_reg, cprio_next;
    logic [7:0]           clife_reg, clife_next;
    result_t              res_reg, res_next;
    logic                 last_reg, last_next;
    logic                 ov_reg, ov_next;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    entry_t               wdata;
    logic [IDX_W-1:0]     raddr;
    entry_t               rdata;
    entry_t               upd;
    logic [ENTRY_W-1:0]   rdata_bits;
    logic [IDX_W-1:0]     pslot;

    ppp_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_SIZE)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_bits)
    );
    assign rdata = entry_t'(rdata_bits);

    ppp_update u_upd (.cfg(cfg), .cur(rdata), .upd(upd));

    // a new request waits until the previous final result has been taken
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign res_valid = ov_reg;
    assign res_data  = res_reg;
    assign res_last  = last_reg;
    assign raddr     = idx_reg[IDX_W-1:0];
    assign pslot     = pidx_reg[IDX_W-1:0];

    // next state and datapath control
    always_comb begin
        state_next   = state_reg;
        alive_next   = alive_reg;
        idx_next     = idx_reg;
        pidx_next    = pidx_reg;
        pv_next      = 1'b0;
        func_next    = func_reg;
        new_next     = new_reg;
        cand_ok_next = cand_ok_reg;
        cand_next    = cand_reg;
        cprio_next   = cprio_reg;
        clife_next   = clife_reg;
        res_next     = res_reg;
        last_next    = last_reg;
        ov_next      = ov_reg;
        we           = 1'b0;
        waddr        = pslot;
        wdata        = upd;
        if (ov_reg && res_ready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    func_next    = in_func;
                    new_next     = in_entry;
                    cand_ok_next = 1'b0;
                    idx_next     = '0;
                    state_next   = (in_func == FUNC_SPAWN) ? S_SCAN : S_TICK;
                end
            end
            // spawn: find free slot, track eviction candidate
            S_SCAN: begin
                res_next = '0;
                if (!alive_reg[raddr]) begin
                    we = 1'b1;
                    waddr = raddr;
                    wdata = new_reg;
                    alive_next[raddr] = 1'b1;
                    res_next.status = ST_FREE;
                    res_next.slot = 5'(raddr);
                    res_next.active_count = 6'($countones(alive_reg) + 1);
                    state_next = S_DONE;
                end else if (pv_reg) begin
                    if (!cand_ok_reg || rdata.pprio > cprio_reg ||
                        (rdata.pprio == cprio_reg && rdata.plife < clife_reg)) begin
                        cand_ok_next = 1'b1;
                        cand_next  = pslot;
                        cprio_next = rdata.pprio;
                        clife_next = rdata.plife;
                    end
                end
                if (state_next == S_SCAN) begin
                    if (idx_reg < (IDX_W+1)'(POOL_SIZE)) begin
                        pidx_next = idx_reg;
                        pv_next   = 1'b1;
                        idx_next  = idx_reg + 1'b1;
                    end else if (!pv_reg) begin
                        res_next.active_count = 6'($countones(alive_reg));
                        if (cand_ok_reg && cprio_reg > new_reg.pprio) begin
                            we = 1'b1;
                            waddr = cand_reg;
                            wdata = new_reg;
                            res_next.status = ST_EVICT;
                            res_next.slot = 5'(cand_reg);
                        end else begin
                            res_next.status = ST_REJECT;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            // tick: read entry, write back update, or clear the live flag when life is zero
            S_TICK: begin
                if (pv_reg && alive_reg[pslot]) begin
                    if (rdata.plife == 8'd0) begin
                        alive_next[pslot] = 1'b0;
                    end else begin
                        we = 1'b1;
                    end
                end
                if (idx_reg < (IDX_W+1)'(POOL_SIZE)) begin
                    pidx_next = idx_reg;
                    pv_next   = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end else if (!pv_reg) begin
                    idx_next   = '0;
                    state_next = S_REPORT;
                end
            end
            // report: issue read of next live entry, or form the final done result after the last slot
            S_REPORT: begin
                if (!ov_next) begin
                    if (idx_reg == (IDX_W+1)'(POOL_SIZE)) begin
                        res_next = '0;
                        res_next.status = ST_DONE;
                        res_next.active_count = 6'($countones(alive_reg));
                        last_next  = 1'b1;
                        ov_next    = 1'b1;
                        state_next = S_IDLE;
                    end else if (alive_reg[raddr]) begin
                        pidx_next  = idx_reg;
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_OUT;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_OUT: begin
                res_next = '0;
                res_next.status = ST_RECORD;
                res_next.slot = 5'(pslot);
                res_next.out_x = rdata.px;
                res_next.out_y = rdata.py;
                res_next.tile = rdata.ptile + {8'd0, rdata.cur_frame};
                res_next.out_palette = rdata.ppal;
                res_next.out_prio = rdata.pprio;
                res_next.active_count = 6'($countones(alive_reg));
                last_next  = 1'b0;
                ov_next    = 1'b1;
                state_next = S_REPORT;
            end
            S_DONE: begin
                if (!ov_next) begin
                    last_next  = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (func_reg == FUNC_SPAWN && state_reg == S_DONE) begin
            // result already formed in scan
            res_next = res_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            alive_reg <= '0;
            ov_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            alive_reg <= alive_next;
            ov_reg    <= ov_next;
            pv_reg    <= pv_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        pidx_reg    <= pidx_next;
        func_reg    <= func_next;
        new_reg     <= new_next;
        cand_ok_reg <= cand_ok_next;
        cand_reg    <= cand_next;
        cprio_reg   <= cprio_next;
        clife_reg   <= clife_next;
        res_reg     <= res_next;
        last_reg    <= last_next;
    end
endmodule
`default_nettype wire

// ===== hdl/priority_particle_pool.sv =====
// top level of the priority particle pool
// spawn: the scan reads one ram entry per cycle
// tick: updates every entry, then reports each live entry and a final done record
// one item at a time; s_tready is high only in idle once the last result has been taken
// reset clears the live flags and restores register defaults; entry ram is not cleared
`default_nettype none
module priority_particle_pool
    import ppp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // kind, prio, pos_x, pos_y, vel_x, vel_y, life, first_tile, palette,
    // frame_total, frame_period, 2 zero bits
    input  wire logic [151:0] s_tdata,
    input  wire logic         s_tuser,   // func
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, slot, out_x, out_y, tile, out_palette, out_prio, active_count, 7 zero bits
    output logic [79:0]       m_tdata,
    output logic              m_tlast
);
    logic [7:0]  mask_reg;
    logic [15:0] step_reg;
    logic [15:0] fall_reg;
    cfg_t        cfg;
    entry_t      ent;
    result_t     res;
    logic [7:0]  frm;
    logic [7:0]  per;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            step_reg <= GRAVITY_STEP_RST;
            fall_reg <= MAX_FALL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRAV_MASK: mask_reg <= cfg_wdata[7:0];
                REG_GRAV_STEP: step_reg <= cfg_wdata;
                REG_MAX_FALL:  fall_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end
    assign cfg = '{grav_mask: mask_reg, grav_step: step_reg, max_fall: fall_reg};

    // unpack a spawn request into a fresh entry
    always_comb begin
        frm = s_tdata[141:134];
        per = s_tdata[149:142];
        ent.ptype      = s_tdata[2:0];
        ent.pprio      = s_tdata[5:3];
        ent.px         = s_tdata[21:6];
        ent.py         = s_tdata[37:22];
        ent.pvx        = s_tdata[69:38];
        ent.pvy        = s_tdata[101:70];
        ent.plife      = s_tdata[109:102];
        ent.ptile      = s_tdata[125:110];
        ent.ppal       = s_tdata[133:126];
        ent.anim_count = 8'd0;
        ent.anim_len   = (per == 8'd0) ? DEF_PERIOD : per;
        ent.cur_frame  = 8'd0;
        ent.num_frames = (frm == 8'd0) ? DEF_FRAMES : frm;
    end

    ppp_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_entry  (ent),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res),
        .res_last  (m_tlast)
    );

    assign m_tdata = {7'd0, res.active_count, res.out_prio, res.out_palette, res.tile,
                      res.out_y, res.out_x, res.slot, res.status};
endmodule
`default_nettype wire

// ===== tb/sv/tb_priority_particle_pool.sv =====
// self-checking testbench for the priority particle pool
`timescale 1ns / 1ps
`default_nettype none
module tb_priority_particle_pool;
    import ppp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 200;

    // one spawn or tick request
    typedef struct {
        bit        func;
        bit [2:0]  kind;
        bit [2:0]  prio;
        bit [15:0] pos_x;
        bit [15:0] pos_y;
        bit [31:0] vel_x;
        bit [31:0] vel_y;
        bit [7:0]  life;
        bit [15:0] first_tile;
        bit [7:0]  palette;
        bit [7:0]  frame_total;
        bit [7:0]  frame_period;
    } request_t;

    // one particle as held by the predictor
    typedef struct {
        bit [2:0]  kind;
        bit [2:0]  prio;
        bit [15:0] px;
        bit [15:0] py;
        bit [31:0] vx;
        bit [31:0] vy;
        bit [7:0]  life;
        bit [15:0] tile;
        bit [7:0]  pal;
        bit [7:0]  anim_count;
        bit [7:0]  anim_len;
        bit [7:0]  frame;
        bit [7:0]  frames;
    } particle_t;

    // one expected output record
    typedef struct {
        bit [2:0]  status;
        bit [4:0]  slot;
        bit [15:0] x;
        bit [15:0] y;
        bit [15:0] tile;
        bit [7:0]  pal;
        bit [2:0]  prio;
        bit [5:0]  count;
        bit        last;
    } record_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic         m_tlast;

    // predictor state
    particle_t pool [POOL_SIZE];
    bit        live [POOL_SIZE];
    bit [7:0]  grav_mask;
    bit [15:0] grav_step;
    bit [15:0] fall_limit;

    record_t pending_records[$];
    int      error_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;

    priority_particle_pool u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run timeout
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < POOL_SIZE; i++) if (live[i]) n++;
        return n;
    endfunction

    function automatic record_t make_record(bit [2:0] st, int slot, int count, bit last);
        record_t r;
        r = '{default: '0};
        r.status = st;
        r.slot   = slot[4:0];
        r.count  = count[5:0];
        r.last   = last;
        return r;
    endfunction

    // place a spawned particle into one slot
    task automatic load_particle(int i, request_t q);
        live[i]            = 1'b1;
        pool[i].kind       = q.kind;
        pool[i].prio       = q.prio;
        pool[i].px         = q.pos_x;
        pool[i].py         = q.pos_y;
        pool[i].vx         = q.vel_x;
        pool[i].vy         = q.vel_y;
        pool[i].life       = q.life;
        pool[i].tile       = q.first_tile;
        pool[i].pal        = q.palette;
        pool[i].anim_count = 8'd0;
        pool[i].anim_len   = (q.frame_period != 0) ? q.frame_period : DEF_PERIOD;
        pool[i].frame      = 8'd0;
        pool[i].frames     = (q.frame_total != 0) ? q.frame_total : DEF_FRAMES;
    endtask

    // spawn: lowest free slot, else evict the least important, or reject
    task automatic predict_spawn(request_t q);
        int victim;
        victim = -1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (!live[i]) begin
                load_particle(i, q);
                pending_records.push_back(make_record(ST_FREE, i, live_count(), 1'b1));
                return;
            end
            if (victim < 0 || pool[i].prio > pool[victim].prio ||
                (pool[i].prio == pool[victim].prio && pool[i].life < pool[victim].life))
                victim = i;
        end
        if (victim >= 0 && pool[victim].prio > q.prio) begin
            load_particle(victim, q);
            pending_records.push_back(make_record(ST_EVICT, victim, live_count(), 1'b1));
        end else begin
            pending_records.push_back(make_record(ST_REJECT, 0, live_count(), 1'b1));
        end
    endtask

    // tick: expire or age, move, apply gravity, animate, then report
    task automatic predict_tick();
        bit [31:0] shifted;
        longint    fall;
        int        count;
        record_t   r;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (!live[i]) continue;
            if (pool[i].life == 0) begin
                live[i] = 1'b0;
                continue;
            end
            pool[i].life--;
            shifted = $signed(pool[i].vx) >>> 8;
            pool[i].px += shifted[15:0];
            shifted = $signed(pool[i].vy) >>> 8;
            pool[i].py += shifted[15:0];
            if (grav_mask[pool[i].kind]) begin
                fall = longint'($signed(pool[i].vy)) + longint'(grav_step);
                if (fall > longint'(fall_limit)) fall = longint'(fall_limit);
                pool[i].vy = fall[31:0];
            end
            if (pool[i].frames > 1) begin
                pool[i].anim_count++;
                if (pool[i].anim_count >= pool[i].anim_len) begin
                    pool[i].anim_count = 8'd0;
                    pool[i].frame++;
                    if (pool[i].frame >= pool[i].frames) pool[i].frame = 8'd0;
                end
            end
        end
        count = live_count();
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (!live[i]) continue;
            r      = make_record(ST_RECORD, i, count, 1'b0);
            r.x    = pool[i].px;
            r.y    = pool[i].py;
            r.tile = pool[i].tile + 16'(pool[i].frame);
            r.pal  = pool[i].pal;
            r.prio = pool[i].prio;
            pending_records.push_back(r);
        end
        pending_records.push_back(make_record(ST_DONE, 0, count, 1'b1));
    endtask

    // send one request, with a random gap ahead of it
    task automatic send_request(request_t q);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = q.func;
        s_tdata  = {2'd0, q.frame_period, q.frame_total, q.palette, q.first_tile, q.life,
                    q.vel_y, q.vel_x, q.pos_y, q.pos_x, q.prio, q.kind};
        do @(posedge aclk); while (!s_tready);
        if (q.func == FUNC_SPAWN) predict_spawn(q);
        else predict_tick();
        @(negedge aclk);
    endtask

    // wait until every expected record has come, plus a settling delay
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_records.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [15:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_GRAV_MASK: grav_mask = value[7:0];
            REG_GRAV_STEP: grav_step = value;
            REG_MAX_FALL: fall_limit = value;
            default: ;
        endcase
    endtask

    function automatic request_t tick_request();
        request_t q;
        q = '{default: '0};
        q.func = FUNC_TICK;
        return q;
    endfunction

    function automatic request_t random_spawn();
        request_t q;
        q.func         = FUNC_SPAWN;
        q.kind         = 3'($urandom_range(7));
        q.prio         = 3'($urandom_range(7));
        q.pos_x        = 16'($urandom);
        q.pos_y        = 16'($urandom);
        q.vel_x        = $urandom;
        q.vel_y        = $urandom;
        q.life         = 8'(($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(255));
        q.first_tile   = 16'($urandom);
        q.palette      = 8'($urandom);
        q.frame_total  = 8'(($urandom_range(3) == 0) ? $urandom_range(255) :
                            $urandom_range(4));
        q.frame_period = 8'(($urandom_range(3) == 0) ? $urandom_range(255) :
                            $urandom_range(3));
        return q;
    endfunction

    // checker for each output record
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_record();
    end

    task automatic check_record();
        record_t     want;
        bit [79:0]   got;
        got = m_tdata;
        if (pending_records.size() == 0) begin
            $display("%0t unexpected record, actual %h last %b", $realtime, m_tdata, m_tlast);
            error_count++;
            return;
        end
        want = pending_records.pop_front();
        if (got[2:0] !== want.status || got[7:3] !== want.slot ||
            got[23:8] !== want.x || got[39:24] !== want.y ||
            got[55:40] !== want.tile || got[63:56] !== want.pal ||
            got[66:64] !== want.prio || got[72:67] !== want.count ||
            m_tlast !== want.last) begin
            $display("%0t mismatch expected st=%0d slot=%0d x=%h y=%h tile=%h pal=%h pr=%0d cnt=%0d last=%b",
                     $realtime, want.status, want.slot, want.x, want.y, want.tile, want.pal,
                     want.prio, want.count, want.last);
            $display("%0t          actual   st=%0d slot=%0d x=%h y=%h tile=%h pal=%h pr=%0d cnt=%0d last=%b",
                     $realtime, got[2:0], got[7:3], got[23:8], got[39:24], got[55:40],
                     got[63:56], got[66:64], got[72:67], m_tlast);
            error_count++;
        end
    endtask

    // field extremes, default period and frame count, zero life expiry
    task automatic test_field_extremes();
        request_t q;
        q = '{default: '0};
        send_request(q);
        q = '{func: FUNC_SPAWN, kind: 3'd7, prio: 3'd7, pos_x: 16'hffff, pos_y: 16'hffff,
              vel_x: 32'hffff_ffff, vel_y: 32'hffff_ffff, life: 8'hff, first_tile: 16'hffff,
              palette: 8'hff, frame_total: 8'hff, frame_period: 8'hff};
        send_request(q);
        q = '{func: FUNC_SPAWN, kind: 3'd1, prio: 3'd3, pos_x: 16'h7fff, pos_y: 16'h8000,
              vel_x: 32'h7fff_ffff, vel_y: 32'h8000_0000, life: 8'd2, first_tile: 16'hfffe,
              palette: 8'h5a, frame_total: 8'd3, frame_period: 8'd1};
        send_request(q);
        repeat (4) send_request(tick_request());
    endtask

    // gravity on every type with clamp and overflow cases
    task automatic test_gravity();
        request_t q;
        write_reg(REG_GRAV_MASK, 16'h00ff);
        write_reg(REG_GRAV_STEP, 16'hffff);
        write_reg(REG_MAX_FALL, 16'h0000);
        q = random_spawn();
        q.vel_y = 32'h7fff_ff00;
        q.life  = 8'd10;
        send_request(q);
        q = random_spawn();
        q.vel_y = 32'h8000_0000;
        q.life  = 8'd10;
        send_request(q);
        repeat (2) send_request(tick_request());
        drain();
        write_reg(REG_MAX_FALL, 16'hffff);
        write_reg(REG_GRAV_STEP, 16'h0000);
        write_reg(REG_GRAV_MASK, 16'h0055);
        repeat (2) send_request(tick_request());
        drain();
    endtask

    // random spawns and ticks; pool fills so eviction and rejection occur
    task automatic test_random_traffic(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 72) send_request(random_spawn());
            else send_request(tick_request());
        end
        drain();
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 35;
        recv_idle_pct = 75;
        grav_mask     = 8'd0;
        grav_step     = GRAVITY_STEP_RST;
        fall_limit    = MAX_FALL_RST;
        for (int i = 0; i < POOL_SIZE; i++) live[i] = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_field_extremes();
        drain();
        test_gravity();

        write_reg(REG_GRAV_MASK, 16'h00a3);
        write_reg(REG_GRAV_STEP, GRAVITY_STEP_RST);
        write_reg(REG_MAX_FALL, MAX_FALL_RST);
        test_random_traffic(160);

        send_idle_pct = 75;
        recv_idle_pct = 35;
        write_reg(REG_GRAV_MASK, 16'd0);
        write_reg(REG_GRAV_STEP, 16'h0300);
        test_random_traffic(160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_GRAV_MASK, 16'h00ff);
        write_reg(REG_MAX_FALL, 16'h8000);
        test_random_traffic(160);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
